// ===== hw/rtl/matern_rbf_kernel_eval_assert.svh =====
// Assertion macros for the kernel evaluator RTL.
`ifndef MATERN_RBF_KERNEL_EVAL_ASSERT_SVH
`define MATERN_RBF_KERNEL_EVAL_ASSERT_SVH
`ifndef SYNTHESIS
`define MRK_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mrk assertion failed");
`define MRK_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("mrk reset check failed");
`else
`define MRK_ASSERT(lbl, prop)
`define MRK_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== hw/rtl/mrk_pkg.sv =====
// Shared types, constants and tables of the kernel evaluator.
package mrk_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int MAX_DIMS    = 64;
  localparam int ACC_W       = 40;
  localparam int IB_W        = 24;
  localparam int CFG_IDX_W   = 8;

  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MODE   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_BANDWIDTH = 8'd1;

  localparam logic [ACC_W-1:0] ACC_MAX   = {ACC_W{1'b1}};
  localparam logic [31:0]      LOG2E_Q16 = 32'd94548;
  localparam logic [31:0]      SQRT3_Q16 = 32'd113512;
  localparam logic [31:0]      SQRT5_Q16 = 32'd146543;
  localparam logic [31:0]      RECIP3    = 32'hAAAAAAAB;

  typedef enum logic [1:0] {
    KM_EXP = 2'd0,
    KM_M15 = 2'd1,
    KM_M25 = 2'd2,
    KM_RBF = 2'd3
  } kmode_t;

  // One finished row pair: its squared distance.
  typedef struct packed {
    logic             valid;
    logic [ACC_W-1:0] acc;
  } entry_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    logic [63:0] rem;
    res  = 64'd0;
    bitv = 64'd1 << 62;
    rem  = v;
    for (int j = 0; j < 32; j++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // 2^-(2^-i) in Q.30 by repeated floor roots from 0.5.
  function automatic logic [29:0] exp_factor(input int i);
    logic [63:0] a;
    a = 64'd1 << 29;
    for (int j = 1; j <= i; j++) begin
      a = isqrt64(a << 30);
    end
    return a[29:0];
  endfunction

  localparam logic [29:0] EXP_FACTOR [16] = '{
    exp_factor(1),  exp_factor(2),  exp_factor(3),  exp_factor(4),
    exp_factor(5),  exp_factor(6),  exp_factor(7),  exp_factor(8),
    exp_factor(9),  exp_factor(10), exp_factor(11), exp_factor(12),
    exp_factor(13), exp_factor(14), exp_factor(15), exp_factor(16)
  };

endpackage

// ===== hw/rtl/mrk_front.sv =====
// Front part: accumulates squared coordinate differences per row pair.
module mrk_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [2*mrk_pkg::COORD_WIDTH-1:0]   in_tdata,
  input  logic                                in_tlast,
  input  logic                                q_full,
  output mrk_pkg::entry_t                     push_o
);

  logic [mrk_pkg::ACC_W-1:0]         acc_r, acc_nxt;
  logic signed [mrk_pkg::COORD_WIDTH:0] diff;
  logic [mrk_pkg::COORD_WIDTH-1:0]   mag;
  logic [2*mrk_pkg::COORD_WIDTH-1:0] sq;
  logic [mrk_pkg::ACC_W:0]           sum;
  logic [mrk_pkg::ACC_W-1:0]         sat;
  logic                              xfer;

  assign in_tready = !q_full;
  assign xfer      = in_tvalid && in_tready;

  always_comb begin
    diff = {in_tdata[mrk_pkg::COORD_WIDTH-1], in_tdata[mrk_pkg::COORD_WIDTH-1:0]}
         - {in_tdata[2*mrk_pkg::COORD_WIDTH-1],
            in_tdata[2*mrk_pkg::COORD_WIDTH-1:mrk_pkg::COORD_WIDTH]};
    mag  = diff[mrk_pkg::COORD_WIDTH] ? mrk_pkg::COORD_WIDTH'(-diff)
                                      : diff[mrk_pkg::COORD_WIDTH-1:0];
    sq   = mag * mag;
    sum  = {1'b0, acc_r} + (mrk_pkg::ACC_W+1)'(sq);
    // saturate at the top of the accumulator
    sat  = (sum >= {1'b0, mrk_pkg::ACC_MAX}) ? mrk_pkg::ACC_MAX : sum[mrk_pkg::ACC_W-1:0];
    acc_nxt = acc_r;
    if (xfer) begin
      acc_nxt = in_tlast ? '0 : sat;
    end
    push_o.valid = xfer && in_tlast;
    push_o.acc   = sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

endmodule

// ===== hw/rtl/mrk_queue.sv =====
// Two-entry queue of squared distances between front and back.
module mrk_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  mrk_pkg::entry_t push_i,
  output logic            full_o,
  input  logic            pop_i,
  output mrk_pkg::entry_t head_o
);

  logic [mrk_pkg::ACC_W-1:0] mem_r [2];
  logic                      wr_ptr_r, rd_ptr_r;
  logic [1:0]                cnt_r;

  assign full_o       = (cnt_r == 2'd2);
  assign head_o.valid = (cnt_r != 2'd0);
  assign head_o.acc   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_i.valid) begin
      mem_r[wr_ptr_r] <= push_i.acc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push_i.valid) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop_i) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push_i.valid} - {1'b0, pop_i};
    end
  end

endmodule

// ===== hw/rtl/mrk_back.sv =====
// Back part: root, exponential and polynomial over one shared multiplier.
`include "matern_rbf_kernel_eval_assert.svh"
module mrk_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mrk_pkg::entry_t           head_i,
  output logic                      pop_o,
  input  mrk_pkg::kmode_t           kernel_mode,
  input  logic [mrk_pkg::IB_W-1:0]  inv_bw,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [15:0]               out_tdata
);

  typedef enum logic [19:0] {
    S_IDLE = 20'h00001,
    S_R1   = 20'h00002,
    S_R2   = 20'h00004,
    S_R3   = 20'h00008,
    S_R4   = 20'h00010,
    S_R5   = 20'h00020,
    S_SQRT = 20'h00040,
    S_M1   = 20'h00080,
    S_M2   = 20'h00100,
    S_M3   = 20'h00200,
    S_M4   = 20'h00400,
    S_E0   = 20'h00800,
    S_E1   = 20'h01000,
    S_EL   = 20'h02000,
    S_EN   = 20'h04000,
    S_P1   = 20'h08000,
    S_Q1   = 20'h10000,
    S_Q2   = 20'h20000,
    S_Q3   = 20'h40000,
    S_OUT  = 20'h80000
  } state_t;

  state_t          state_r, state_nxt;
  mrk_pkg::kmode_t mode_r, mode_nxt;
  logic [mrk_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic [71:0] w_r, w_nxt;
  logic [15:0] hi_r, hi_nxt;
  logic [47:0] src_r, src_nxt;
  logic [25:0] rem_r, rem_nxt;
  logic [23:0] root_r, root_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [21:0] t_r, t_nxt;
  logic [21:0] s_r, s_nxt;
  logic [15:0] u_r, u_nxt;
  logic [4:0]  n_r, n_nxt;
  logic [3:0]  k_r, k_nxt;
  logic [30:0] r_r, r_nxt;
  logic [30:0] e_r, e_nxt;
  logic [41:0] fin_r, fin_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_data_r, out_data_nxt;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [27:0] remx, trial;
  logic [30:0] e_val;
  logic [27:0] poly;
  logic [42:0] rnd;
  logic        out_free;

  assign mul_p      = mul_a * mul_b;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    acc_nxt       = acc_r;
    w_nxt         = w_r;
    hi_nxt        = hi_r;
    src_nxt       = src_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    cnt_nxt       = cnt_r;
    t_nxt         = t_r;
    s_nxt         = s_r;
    u_nxt         = u_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    r_nxt         = r_r;
    e_nxt         = e_r;
    fin_nxt       = fin_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    pop_o         = 1'b0;
    mul_a         = '0;
    mul_b         = {8'b0, inv_bw};
    remx          = {rem_r, src_r[47:46]};
    trial         = {2'b0, root_r, 2'b01};
    e_val         = r_r >> n_r;
    poly          = 28'd65536 + 28'(s_r) + {1'b0, w_r[59:33]};
    rnd           = {1'b0, fin_r} + 43'd16384;
    case (state_r)
      S_IDLE: begin
        if (head_i.valid) begin
          pop_o    = 1'b1;
          acc_nxt  = head_i.acc;
          mode_nxt = kernel_mode;
          src_nxt  = {head_i.acc, 8'b0};
          rem_nxt  = '0;
          root_nxt = '0;
          cnt_nxt  = 5'd23;
          state_nxt = (kernel_mode == mrk_pkg::KM_RBF) ? S_R1 : S_SQRT;
        end
      end
      // RBF: acc * ib, then (>> 16) * ib, each split into two partial products
      S_R1: begin
        mul_a     = acc_r[31:0];
        w_nxt     = {8'b0, mul_p};
        state_nxt = S_R2;
      end
      S_R2: begin
        mul_a     = {24'b0, acc_r[39:32]};
        w_nxt     = w_r + {mul_p[39:0], 32'b0};
        state_nxt = S_R3;
      end
      S_R3: begin
        mul_a     = w_r[47:16];
        hi_nxt    = w_r[63:48];
        w_nxt     = {8'b0, mul_p};
        state_nxt = S_R4;
      end
      S_R4: begin
        mul_a     = {16'b0, hi_r};
        w_nxt     = w_r + {mul_p[39:0], 32'b0};
        state_nxt = S_R5;
      end
      S_R5: begin
        if (|w_r[71:47]) begin
          fin_nxt   = '0;
          state_nxt = S_OUT;
        end else begin
          t_nxt     = w_r[46:25];
          state_nxt = S_E0;
        end
      end
      // one root bit per cycle
      S_SQRT: begin
        src_nxt = {src_r[45:0], 2'b00};
        if (remx >= trial) begin
          rem_nxt  = 26'(remx - trial);
          root_nxt = {root_r[22:0], 1'b1};
        end else begin
          rem_nxt  = remx[25:0];
          root_nxt = {root_r[22:0], 1'b0};
        end
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          state_nxt = S_M1;
        end
      end
      S_M1: begin
        mul_a     = {8'b0, root_r};
        w_nxt     = {8'b0, mul_p};
        state_nxt = S_M2;
      end
      S_M2: begin
        if (|w_r[47:38]) begin
          fin_nxt   = '0;
          state_nxt = S_OUT;
        end else begin
          t_nxt     = w_r[37:16];
          state_nxt = (mode_r == mrk_pkg::KM_EXP) ? S_E0 : S_M3;
        end
      end
      S_M3: begin
        mul_a     = {10'b0, t_r};
        mul_b     = (mode_r == mrk_pkg::KM_M15) ? mrk_pkg::SQRT3_Q16 : mrk_pkg::SQRT5_Q16;
        w_nxt     = {8'b0, mul_p};
        state_nxt = S_M4;
      end
      S_M4: begin
        if (|w_r[47:38]) begin
          fin_nxt   = '0;
          state_nxt = S_OUT;
        end else begin
          t_nxt     = w_r[37:16];
          s_nxt     = w_r[37:16];
          state_nxt = S_E0;
        end
      end
      S_E0: begin
        mul_a     = {10'b0, t_r};
        mul_b     = mrk_pkg::LOG2E_Q16;
        w_nxt     = {8'b0, mul_p};
        state_nxt = S_E1;
      end
      S_E1: begin
        u_nxt = w_r[31:16];
        k_nxt = 4'd0;
        if (w_r[38:32] >= 7'd31) begin
          r_nxt     = '0;
          n_nxt     = '0;
          state_nxt = S_EN;
        end else begin
          r_nxt     = 31'h40000000;
          n_nxt     = w_r[36:32];
          state_nxt = S_EL;
        end
      end
      // one fraction bit of the base-2 exponent per cycle, msb first
      S_EL: begin
        mul_a = {1'b0, r_r};
        mul_b = {2'b0, mrk_pkg::EXP_FACTOR[k_r]};
        if (u_r[15]) begin
          r_nxt = mul_p[60:30];
        end
        u_nxt = {u_r[14:0], 1'b0};
        k_nxt = k_r + 4'd1;
        if (k_r == 4'd15) begin
          state_nxt = S_EN;
        end
      end
      S_EN: begin
        e_nxt = e_val;
        case (mode_r)
          mrk_pkg::KM_M15: state_nxt = S_P1;
          mrk_pkg::KM_M25: state_nxt = S_Q1;
          default: begin
            fin_nxt   = {11'b0, e_val};
            state_nxt = S_OUT;
          end
        endcase
      end
      S_P1: begin
        mul_a     = {1'b0, e_r};
        mul_b     = 32'd65536 + {10'b0, s_r};
        fin_nxt   = mul_p[57:16];
        state_nxt = S_OUT;
      end
      S_Q1: begin
        mul_a     = {10'b0, s_r};
        mul_b     = {10'b0, s_r};
        w_nxt     = {8'b0, mul_p};
        state_nxt = S_Q2;
      end
      S_Q2: begin
        // divide by three through the reciprocal, exact below 2^32
        mul_a     = {4'b0, w_r[43:16]};
        mul_b     = mrk_pkg::RECIP3;
        w_nxt     = {8'b0, mul_p};
        state_nxt = S_Q3;
      end
      S_Q3: begin
        mul_a     = {1'b0, e_r};
        mul_b     = {4'b0, poly};
        fin_nxt   = mul_p[57:16];
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = (rnd[42:15] > 28'd32768) ? 16'h8000 : rnd[30:15];
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    acc_r      <= acc_nxt;
    w_r        <= w_nxt;
    hi_r       <= hi_nxt;
    src_r      <= src_nxt;
    rem_r      <= rem_nxt;
    root_r     <= root_nxt;
    cnt_r      <= cnt_nxt;
    t_r        <= t_nxt;
    s_r        <= s_nxt;
    u_r        <= u_nxt;
    n_r        <= n_nxt;
    k_r        <= k_nxt;
    r_r        <= r_nxt;
    e_r        <= e_nxt;
    fin_r      <= fin_nxt;
    out_data_r <= out_data_nxt;
  end

  `MRK_ASSERT(a_pop_idle, pop_o |-> (state_r == S_IDLE) && head_i.valid)
  `MRK_ASSERT(a_sqrt_done, (state_r == S_SQRT) && (cnt_r == 5'd0) |=> (state_r == S_M1))
  `MRK_ASSERT(a_out_load, (state_r == S_OUT) && out_free |=> out_valid_r && (state_r == S_IDLE))

endmodule

// ===== hw/rtl/matern_rbf_kernel_eval.sv =====
// Matern / RBF kernel evaluator top level: configuration registers and wiring.
//
// Coordinates are taken one per cycle; the front part keeps taking them while
// up to two finished row pairs wait in the queue for the back part, and stalls
// its input once both queue slots are taken. Each row pair's kernel is then
// computed in the back part on one shared 32x32 multiplier: RBF scales and
// exponentiates, the other modes take the bit-serial square root first, and
// Matern adds its polynomial. The back part pops the next row pair only from
// idle, after it has loaded the output register. A stalled output register
// holds the back part in its last step. The 16-step exponential loop and the
// square root make up most of the work per row pair.
module matern_rbf_kernel_eval (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [2*mrk_pkg::COORD_WIDTH-1:0] in_tdata, // x_coord, y_coord
  input  logic                            in_tlast,   // last_coord
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [15:0]                     out_tdata,  // kernel_value
  input  logic                            cfg_wr_en,
  input  logic [mrk_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mrk_pkg::IB_W-1:0]        cfg_wdata
);

  mrk_pkg::kmode_t             kmode_r;
  logic [mrk_pkg::IB_W-1:0]    ib_r;
  mrk_pkg::entry_t             push;
  mrk_pkg::entry_t             head;
  logic                        q_full;
  logic                        pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kmode_r <= mrk_pkg::KM_RBF;
      ib_r    <= 24'd65536;
    end else if (cfg_wr_en) begin
      if (cfg_index == mrk_pkg::REG_KERNEL_MODE) begin
        kmode_r <= mrk_pkg::kmode_t'(cfg_wdata[1:0]);
      end else if (cfg_index == mrk_pkg::REG_INV_BANDWIDTH) begin
        ib_r <= cfg_wdata;
      end
    end
  end

  mrk_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .push_o    (push)
  );

  mrk_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (push),
    .full_o (q_full),
    .pop_i  (pop),
    .head_o (head)
  );

  mrk_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_i      (head),
    .pop_o       (pop),
    .kernel_mode (kmode_r),
    .inv_bw      (ib_r),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule

// ===== tb/matern_rbf_kernel_eval_test.sv =====
// Self-checking testbench for the Matern / RBF kernel evaluator.
module matern_rbf_kernel_eval_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 6000;
  localparam int SETTLE_CYC = 120;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // x_coord [15:0], y_coord [31:16]
  logic        in_tlast = 1'b0; // last_coord
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // kernel_value
  logic        cfg_wr_en = 1'b0;
  logic [mrk_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mrk_pkg::IB_W-1:0]      cfg_wdata = '0;

  // Predictor state
  mrk_pkg::kmode_t          mode_q;
  logic [mrk_pkg::IB_W-1:0] inv_bw;
  longint unsigned          dist_sq;
  logic [15:0]              kernel_q[$];

  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  tx_idle = 1'b1;
  bit  rx_idle = 1'b1;
  int  hold_cycles = 0;

  matern_rbf_kernel_eval u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  // exp(-t), t in Q.16, result in Q.30 via 2^-u
  function automatic longint unsigned exp_neg(input longint unsigned t);
    longint unsigned u, n, acc, f;
    u = (t * 94548) >> 16;
    n = u >> 16;
    acc = 64'd1 << 30;
    f = 64'd1 << 29;
    if (n >= 31) return 0;
    for (int i = 1; i <= 16; i++) begin
      f = floor_sqrt(f << 30);
      if ((u >> (16 - i)) & 1) acc = (acc * f) >> 30;
    end
    return acc >> n;
  endfunction

  function automatic logic [15:0] round_q15(input longint unsigned v30);
    longint unsigned o;
    o = (v30 + (64'd1 << 14)) >> 15;
    return (o > 32768) ? 16'd32768 : o[15:0];
  endfunction

  function automatic logic [15:0] kernel_of_dist();
    longint unsigned ib, p, t24, r, s, e;
    ib = 64'(inv_bw);
    if (mode_q == mrk_pkg::KM_RBF) begin
      p = (dist_sq * ib) >> 16;
      if (p != 0 && ib > (64'hFFFF_FFFF_FFFF_FFFF / p)) return 16'd0;
      t24 = (p * ib) >> 17;
      if (t24 >= (64'd64 << 24)) return 16'd0;
      return round_q15(exp_neg(t24 >> 8));
    end
    r = floor_sqrt(dist_sq << 8);
    s = (r * ib) >> 16;
    if (s >= (64'd64 << 16)) return 16'd0;
    if (mode_q == mrk_pkg::KM_EXP) return round_q15(exp_neg(s));
    s = (s * ((mode_q == mrk_pkg::KM_M15) ? 64'd113512 : 64'd146543)) >> 16;
    if (s >= (64'd64 << 16)) return 16'd0;
    e = exp_neg(s);
    if (mode_q == mrk_pkg::KM_M15) return round_q15((e * (65536 + s)) >> 16);
    return round_q15((e * (65536 + s + ((s * s) >> 16) / 3)) >> 16);
  endfunction

  task automatic accumulate_coord(input logic [15:0] x, input logic [15:0] y,
                                  input bit last);
    longint d, mag;
    longint unsigned sq;
    d = longint'($signed(x)) - longint'($signed(y));
    mag = (d < 0) ? -d : d;
    sq = mag * mag;
    if (sq >= 64'(mrk_pkg::ACC_MAX) - dist_sq) dist_sq = 64'(mrk_pkg::ACC_MAX);
    else dist_sq += sq;
    if (last) begin
      kernel_q.insert(kernel_q.size(), kernel_of_dist());
      dist_sq = 0;
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_coord(input logic [15:0] x, input logic [15:0] y, input bit last);
    int gap;
    gap = tx_idle ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {y, x};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    accumulate_coord(x, y, last);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (kernel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Write both registers plus one out-of-map index, which must be ignored.
  task automatic set_config(input mrk_pkg::kmode_t m, input logic [mrk_pkg::IB_W-1:0] ib);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= mrk_pkg::REG_KERNEL_MODE;
    cfg_wdata <= (mrk_pkg::IB_W'($urandom) & ~24'd3) | {22'd0, m};
    @(posedge clk);
    mode_q = m;
    cfg_index <= mrk_pkg::REG_INV_BANDWIDTH;
    cfg_wdata <= ib;
    @(posedge clk);
    inv_bw = ib;
    cfg_index <= mrk_pkg::CFG_IDX_W'($urandom_range(2, 255));
    cfg_wdata <= mrk_pkg::IB_W'($urandom);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_row(input int len, input int spread);
    logic [15:0] x, y;
    for (int i = 0; i < len; i++) begin
      x = 16'($urandom);
      case (spread)
        0: y = x + 16'($urandom_range(0, 512)) - 16'd256;
        1: y = x + 16'($urandom_range(0, 8192)) - 16'd4096;
        default: y = 16'($urandom);
      endcase
      send_coord(x, y, i == len - 1);
    end
  endtask

  task automatic test_directed();
    mrk_pkg::kmode_t m;
    // Reset defaults: RBF, bandwidth 1.0
    send_coord(16'h1234, 16'h1234, 1'b1);
    send_coord(16'h7FFF, 16'h8000, 1'b1);
    send_coord(16'h8000, 16'h7FFF, 1'b1);
    send_coord(16'h0000, 16'h0800, 1'b0);
    send_coord(16'hF800, 16'h0000, 1'b1);
    for (int k = 0; k < 4; k++) begin
      m = mrk_pkg::kmode_t'(k);
      set_config(m, 24'd65536);
      send_coord(16'h0000, 16'h0000, 1'b1);
      send_coord(16'h1000, 16'h0000, 1'b1);
      send_coord(16'h0100, 16'h0000, 1'b0);
      send_coord(16'h0000, 16'h0180, 1'b1);
      set_config(m, 24'hFFFFFF);   // huge inverse bandwidth; the far pair goes to zero
      send_coord(16'h7FFF, 16'h8000, 1'b1);
      send_coord(16'h0001, 16'h0000, 1'b1);
      set_config(m, 24'd1);
      send_coord(16'h7FFF, 16'h8000, 1'b1);
      set_config(m, 24'd0);        // infinite bandwidth
      send_coord(16'h4000, 16'hC000, 1'b1);
    end
  endtask

  task automatic test_saturation();
    set_config(mrk_pkg::KM_EXP, 24'd2);
    for (int i = 0; i < 260; i++)
      send_coord(16'h7FFF, 16'h8000, i == 259);
    set_config(mrk_pkg::KM_RBF, 24'd1);
    for (int i = 0; i < 260; i++)
      send_coord(16'h8000, 16'h7FFF, i == 259);
  endtask

  task automatic test_backpressure();
    set_config(mrk_pkg::KM_M25, 24'd40000);
    tx_idle = 1'b0;
    hold_cycles = 400;
    for (int i = 0; i < 40; i++) send_row(1, 0);
    tx_idle = 1'b1;
  endtask

  task automatic test_random();
    logic [mrk_pkg::IB_W-1:0] ib;
    int sel, n;
    for (int ph = 0; ph < 7; ph++) begin
      sel = $urandom_range(0, 9);
      if (sel < 6) ib = mrk_pkg::IB_W'($urandom_range(1024, 262144));
      else if (sel < 8) ib = mrk_pkg::IB_W'($urandom_range(1, 24'hFFFFFF));
      else if (sel < 9) ib = 24'hFFFFFF;
      else ib = 24'd1;
      set_config(mrk_pkg::kmode_t'($urandom_range(0, 3)), ib);
      tx_idle = (ph % 4) != 3;
      rx_idle = (ph % 5) != 4;
      n = 0;
      while (n < 55) begin
        sel = $urandom_range(0, 19);
        if (sel == 0) begin
          send_row($urandom_range(20, 64), $urandom_range(0, 2));
          n += 20;
        end else begin
          send_row($urandom_range(1, 6), (sel < 12) ? 0 : (sel < 17) ? 1 : 2);
          n += 3;
        end
      end
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // Result side readiness, with random stalls and requested hold-offs
  initial begin : ready_driver
    int gap;
    gap = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        hold_cycles--;
      end else if (gap > 0) begin
        out_tready <= 1'b0;
        gap--;
      end else begin
        out_tready <= 1'b1;
        if (rx_idle) gap = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (kernel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected kernel_value %0d", out_tdata);
      end else begin
        if (out_tdata !== kernel_q[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("kernel_value mismatch: expected %0d actual %0d", kernel_q[0], out_tdata);
        end
        void'(kernel_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    mode_q  = mrk_pkg::KM_RBF;
    inv_bw  = 24'd65536;
    dist_sq = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_saturation();
    test_backpressure();
    test_random();
    drain();
    if (mismatches == 0 && kernel_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
